[hw/rtl/pcs_pkg.sv]
// shared types and constants of the priority compaction scheduler
`timescale 1ns / 1ps
`default_nettype none
package pcs_pkg;

	// default table sizes
	localparam int PendDepthDef = 16;
	localparam int BusyDepthDef = 8;

	// field widths fixed by the item format
	localparam int IdW   = 16;
	localparam int PrioW = 16;

	typedef enum logic [1:0] {
		ACT_REQUEST  = 2'd0,
		ACT_TAKE     = 2'd1,
		ACT_COMPLETE = 2'd2,
		ACT_QUERY    = 2'd3
	} action_t;

	typedef enum logic [1:0] {
		ST_OK        = 2'd0,
		ST_NONE      = 2'd1,
		ST_PEND_FULL = 2'd2,
		ST_BUSY_FULL = 2'd3
	} status_t;

	typedef enum logic [2:0] {
		S_IDLE,
		S_SCAN,
		S_DRAIN,
		S_FIN,
		S_OUT
	} state_t;

	// sequencer strobes toward the evaluation logic
	typedef struct packed {
		logic clr;      // new item, clear the scan accumulators
		logic hit_vld;  // read data of one scan slot is present
		logic commit;   // apply the table updates of this item
	} ctl_t;

	// result of one item
	typedef struct packed {
		status_t          status;
		logic [IdW-1:0]   pick_id;
		logic             is_pending;
	} rsp_t;

endpackage
`default_nettype wire

[hw/rtl/pcs_req_if.sv]
// input item channel of the priority compaction scheduler
`timescale 1ns / 1ps
`default_nettype none
interface pcs_req_if;
	logic        valid;
	logic        ready;
	logic [1:0]  action;
	logic [15:0] part_id;
	logic signed [15:0] priority_req;

	modport source (output valid, output action, output part_id,
		output priority_req, input ready);
	modport sink (input valid, input action, input part_id,
		input priority_req, output ready);
	modport monitor (input valid, input ready, input action, input part_id,
		input priority_req);
endinterface
`default_nettype wire

[hw/rtl/pcs_rsp_if.sv]
// result channel of the priority compaction scheduler
`timescale 1ns / 1ps
`default_nettype none
interface pcs_rsp_if;
	logic        valid;
	logic        ready;
	logic [1:0]  status;
	logic [15:0] pick_id;
	logic        is_pending;

	modport source (output valid, output status, output pick_id,
		output is_pending, input ready);
	modport sink (input valid, input status, input pick_id,
		input is_pending, output ready);
	modport monitor (input valid, input ready, input status, input pick_id,
		input is_pending);
endinterface
`default_nettype wire

[hw/rtl/pcs_ram.sv]
// single port write, single port read memory with registered read data
`timescale 1ns / 1ps
`default_nettype none
module pcs_ram #(
	parameter int DEPTH = 16,
	parameter int WIDTH = 16,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  wire logic             clk,
	input  wire logic             we,
	input  wire logic [AW-1:0]    waddr,
	input  wire logic [WIDTH-1:0] wdata,
	input  wire logic             re,
	input  wire logic [AW-1:0]    raddr,
	output logic      [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	// write port
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	// read port, registered read data
	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule
`default_nettype wire

[hw/rtl/pcs_eval.sv]
// scan evaluation, table flags and commit of one scheduler item
`timescale 1ns / 1ps
`default_nettype none
module pcs_eval import pcs_pkg::*; #(
	parameter int PENDING_DEPTH = PendDepthDef,
	parameter int BUSY_DEPTH    = BusyDepthDef,
	localparam int PW     = $clog2(PENDING_DEPTH),
	localparam int BW     = (BUSY_DEPTH > 1) ? $clog2(BUSY_DEPTH) : 1,
	localparam int SCAN_N = (PENDING_DEPTH > BUSY_DEPTH) ? PENDING_DEPTH : BUSY_DEPTH,
	localparam int SCAN_W = $clog2(SCAN_N)
) (
	input  wire logic                     clk,
	input  wire logic                     arst_n,
	input  wire ctl_t                     ctl,
	input  wire logic [SCAN_W-1:0]        idx,
	input  wire action_t                  action,
	input  wire logic [IdW-1:0]           req_id,
	input  wire logic signed [PrioW-1:0]  req_prio,
	input  wire logic [IdW+PrioW-1:0]     pend_rdata,
	input  wire logic [IdW-1:0]           busy_rdata,
	output logic                          pend_we,
	output logic [PW-1:0]                 pend_waddr,
	output logic [IdW+PrioW-1:0]          pend_wdata,
	output logic                          busy_we,
	output logic [BW-1:0]                 busy_waddr,
	output logic [IdW-1:0]                busy_wdata,
	output rsp_t                          rsp
);

	// per-slot flags; pend_busy_q marks a pending id that is also in service
	logic [PENDING_DEPTH-1:0] pend_valid_q;
	logic [PENDING_DEPTH-1:0] pend_busy_q;
	logic [BUSY_DEPTH-1:0]    busy_valid_q;

	// scan accumulators
	logic                    pm_hit_q;   // id found in pending table
	logic [PW-1:0]           pm_idx_q;
	logic signed [PrioW-1:0] pm_prio_q;
	logic                    pf_hit_q;   // lowest free pending slot
	logic [PW-1:0]           pf_idx_q;
	logic                    bm_hit_q;   // id found in busy set
	logic [BW-1:0]           bm_idx_q;
	logic                    bf_hit_q;   // lowest free busy entry
	logic [BW-1:0]           bf_idx_q;
	logic                    best_hit_q; // best take-next candidate
	logic [PW-1:0]           best_idx_q;
	logic signed [PrioW-1:0] best_prio_q;
	logic [IdW-1:0]          best_id_q;

	logic [PW-1:0]           pi;
	logic [BW-1:0]           bj;
	logic                    pend_in;
	logic                    busy_in;
	logic [IdW-1:0]          rd_id;
	logic signed [PrioW-1:0] rd_prio;
	logic                    rd_pv;
	logic                    rd_bv;
	logic                    elig;
	logic                    better;
	logic                    take_ok;
	logic                    raise;

	// slot decode of the data returned this cycle
	always_comb begin
		pi      = idx[PW-1:0];
		bj      = idx[BW-1:0];
		pend_in = {1'b0, idx} < (SCAN_W+1)'(PENDING_DEPTH);
		busy_in = {1'b0, idx} < (SCAN_W+1)'(BUSY_DEPTH);
		rd_id   = pend_rdata[IdW+PrioW-1:PrioW];
		rd_prio = pend_rdata[PrioW-1:0];
		rd_pv   = pend_in && pend_valid_q[pi];
		rd_bv   = busy_in && busy_valid_q[bj];
		elig    = rd_pv && !rd_prio[PrioW-1] && !pend_busy_q[pi];
		better  = !best_hit_q || (rd_prio > best_prio_q) ||
			((rd_prio == best_prio_q) && (rd_id < best_id_q));
	end

	// hit bits of the accumulators
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pm_hit_q   <= 1'b0;
			pf_hit_q   <= 1'b0;
			bm_hit_q   <= 1'b0;
			bf_hit_q   <= 1'b0;
			best_hit_q <= 1'b0;
		end else if (ctl.clr) begin
			pm_hit_q   <= 1'b0;
			pf_hit_q   <= 1'b0;
			bm_hit_q   <= 1'b0;
			bf_hit_q   <= 1'b0;
			best_hit_q <= 1'b0;
		end else if (ctl.hit_vld) begin
			if (rd_pv && (rd_id == req_id)) begin
				pm_hit_q <= 1'b1;
			end
			if (pend_in && !rd_pv) begin
				pf_hit_q <= 1'b1;
			end
			if (rd_bv && (busy_rdata == req_id)) begin
				bm_hit_q <= 1'b1;
			end
			if (busy_in && !rd_bv) begin
				bf_hit_q <= 1'b1;
			end
			if (elig) begin
				best_hit_q <= 1'b1;
			end
		end
	end

	// payload of the accumulators
	always_ff @(posedge clk) begin
		if (ctl.hit_vld) begin
			if (rd_pv && (rd_id == req_id)) begin
				pm_idx_q  <= pi;
				pm_prio_q <= rd_prio;
			end
			if (pend_in && !rd_pv && !pf_hit_q) begin
				pf_idx_q <= pi;
			end
			if (rd_bv && (busy_rdata == req_id)) begin
				bm_idx_q <= bj;
			end
			if (busy_in && !rd_bv && !bf_hit_q) begin
				bf_idx_q <= bj;
			end
			if (elig && better) begin
				best_idx_q  <= pi;
				best_prio_q <= rd_prio;
				best_id_q   <= rd_id;
			end
		end
	end

	// commit decisions
	always_comb begin
		raise   = req_prio > pm_prio_q;
		take_ok = (action == ACT_TAKE) && best_hit_q && bf_hit_q;

		pend_we    = ctl.commit && (action == ACT_REQUEST) &&
			(pm_hit_q ? raise : pf_hit_q);
		pend_waddr = pm_hit_q ? pm_idx_q : pf_idx_q;
		pend_wdata = {req_id, req_prio};

		busy_we    = ctl.commit && take_ok;
		busy_waddr = bf_idx_q;
		busy_wdata = best_id_q;
	end

	// result of the item
	always_comb begin
		rsp.status     = ST_OK;
		rsp.pick_id    = '0;
		rsp.is_pending = 1'b0;
		case (action)
			ACT_REQUEST: begin
				if (!pm_hit_q && !pf_hit_q) begin
					rsp.status = ST_PEND_FULL;
				end
			end
			ACT_TAKE: begin
				if (!best_hit_q) begin
					rsp.status = ST_NONE;
				end else if (!bf_hit_q) begin
					rsp.status = ST_BUSY_FULL;
				end else begin
					rsp.pick_id = best_id_q;
				end
			end
			ACT_QUERY: begin
				rsp.is_pending = pm_hit_q;
			end
			default: begin
				rsp.status = ST_OK;
			end
		endcase
	end

	// flag updates at commit
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pend_valid_q <= '0;
			pend_busy_q  <= '0;
			busy_valid_q <= '0;
		end else if (ctl.commit) begin
			case (action)
				ACT_REQUEST: begin
					if (!pm_hit_q && pf_hit_q) begin
						pend_valid_q[pf_idx_q] <= 1'b1;
						pend_busy_q[pf_idx_q]  <= bm_hit_q;
					end
				end
				ACT_TAKE: begin
					if (take_ok) begin
						pend_valid_q[best_idx_q] <= 1'b0;
						busy_valid_q[bf_idx_q]   <= 1'b1;
					end
				end
				ACT_COMPLETE: begin
					if (bm_hit_q) begin
						busy_valid_q[bm_idx_q] <= 1'b0;
						if (pm_hit_q) begin
							pend_busy_q[pm_idx_q] <= 1'b0;
						end
					end
				end
				default: begin
					pend_valid_q <= pend_valid_q;
				end
			endcase
		end
	end

endmodule
`default_nettype wire

[hw/rtl/priority_compaction_scheduler_unit.sv]
// top level of the priority compaction scheduler
// Keeps up to PENDING_DEPTH pending partition ids with signed Q8.8 priorities
// and up to BUSY_DEPTH ids in service. Every item, whatever its action, walks
// both tables once through their memory read ports, one slot per cycle, then
// commits its updates in a single cycle and loads the result register. An
// item occupies the block from acceptance until its result is loaded into the
// result register, and only then can the next item be accepted. The result
// register frees the input side, so a new item is accepted while an earlier
// result still waits to be taken. The block needs no clearing pass after
// reset.
`timescale 1ns / 1ps
`default_nettype none
module priority_compaction_scheduler_unit import pcs_pkg::*; #(
	parameter int PENDING_DEPTH = PendDepthDef,
	parameter int BUSY_DEPTH    = BusyDepthDef
) (
	input  wire logic clk,
	input  wire logic arst_n,
	pcs_req_if.sink   req,
	pcs_rsp_if.source rsp
);

	localparam int PW     = $clog2(PENDING_DEPTH);
	localparam int BW     = (BUSY_DEPTH > 1) ? $clog2(BUSY_DEPTH) : 1;
	localparam int SCAN_N = (PENDING_DEPTH > BUSY_DEPTH) ? PENDING_DEPTH : BUSY_DEPTH;
	localparam int SCAN_W = $clog2(SCAN_N);
	localparam logic [SCAN_W-1:0] ScanLast = SCAN_W'(SCAN_N - 1);

	state_t state_q, state_d;
	logic [SCAN_W-1:0]       cnt_q;
	logic [SCAN_W-1:0]       cnt_s1;
	logic                    scan_vld_s1;
	action_t                 act_q;
	logic [IdW-1:0]          id_q;
	logic signed [PrioW-1:0] prio_q;
	logic                    rsp_valid_q;
	rsp_t                    rsp_q;

	ctl_t                    ctl;
	logic                    rd_en;
	logic                    accept;
	logic                    out_free;
	logic                    out_load;
	rsp_t                    eval_rsp;

	logic                    pend_we;
	logic [PW-1:0]           pend_waddr;
	logic [IdW+PrioW-1:0]    pend_wdata;
	logic [IdW+PrioW-1:0]    pend_rdata;
	logic                    busy_we;
	logic [BW-1:0]           busy_waddr;
	logic [IdW-1:0]          busy_wdata;
	logic [IdW-1:0]          busy_rdata;

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			S_IDLE:  if (req.valid) state_d = S_SCAN;
			S_SCAN:  if (cnt_q == ScanLast) state_d = S_DRAIN;
			S_DRAIN: state_d = S_FIN;
			S_FIN:   state_d = S_OUT;
			S_OUT:   if (out_free) state_d = S_IDLE;
			default: state_d = S_IDLE;
		endcase
	end

	// sequencer outputs
	always_comb begin
		out_free    = !rsp_valid_q || rsp.ready;
		req.ready   = (state_q == S_IDLE);
		accept      = (state_q == S_IDLE) && req.valid;
		rd_en       = (state_q == S_SCAN);
		out_load    = (state_q == S_OUT) && out_free;
		ctl.clr     = accept;
		ctl.hit_vld = scan_vld_s1;
		ctl.commit  = (state_q == S_FIN);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// slot counter and its read-data stage
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q       <= '0;
			scan_vld_s1 <= 1'b0;
		end else begin
			scan_vld_s1 <= rd_en;
			if (accept) begin
				cnt_q <= '0;
			end else if (rd_en) begin
				cnt_q <= cnt_q + 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		cnt_s1 <= cnt_q;
	end

	// item capture
	always_ff @(posedge clk) begin
		if (accept) begin
			act_q  <= action_t'(req.action);
			id_q   <= req.part_id;
			prio_q <= req.priority_req;
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (out_load) begin
			rsp_valid_q <= 1'b1;
		end else if (rsp.ready) begin
			rsp_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			rsp_q <= eval_rsp;
		end
	end

	always_comb begin
		rsp.valid      = rsp_valid_q;
		rsp.status     = rsp_q.status;
		rsp.pick_id    = rsp_q.pick_id;
		rsp.is_pending = rsp_q.is_pending;
	end

	// pending table: {id, priority}
	pcs_ram #(
		.DEPTH (PENDING_DEPTH),
		.WIDTH (IdW + PrioW)
	) u_pend_ram (
		.clk   (clk),
		.we    (pend_we),
		.waddr (pend_waddr),
		.wdata (pend_wdata),
		.re    (rd_en),
		.raddr (cnt_q[PW-1:0]),
		.rdata (pend_rdata)
	);

	// busy set ids
	pcs_ram #(
		.DEPTH (BUSY_DEPTH),
		.WIDTH (IdW)
	) u_busy_ram (
		.clk   (clk),
		.we    (busy_we),
		.waddr (busy_waddr),
		.wdata (busy_wdata),
		.re    (rd_en),
		.raddr (cnt_q[BW-1:0]),
		.rdata (busy_rdata)
	);

	pcs_eval #(
		.PENDING_DEPTH (PENDING_DEPTH),
		.BUSY_DEPTH    (BUSY_DEPTH)
	) u_eval (
		.clk        (clk),
		.arst_n     (arst_n),
		.ctl        (ctl),
		.idx        (cnt_s1),
		.action     (act_q),
		.req_id     (id_q),
		.req_prio   (prio_q),
		.pend_rdata (pend_rdata),
		.busy_rdata (busy_rdata),
		.pend_we    (pend_we),
		.pend_waddr (pend_waddr),
		.pend_wdata (pend_wdata),
		.busy_we    (busy_we),
		.busy_waddr (busy_waddr),
		.busy_wdata (busy_wdata),
		.rsp        (eval_rsp)
	);

endmodule
`default_nettype wire

[hw/rtl/pcs_checker.sv]
// port checks of the priority compaction scheduler and their binding
`timescale 1ns / 1ps
`default_nettype none
module pcs_checker import pcs_pkg::*; (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire logic           req_valid,
	input  wire logic           req_ready,
	input  wire logic           rsp_valid,
	input  wire logic           rsp_ready,
	input  wire logic [1:0]     rsp_status,
	input  wire logic [IdW-1:0] rsp_pick_id,
	input  wire logic           rsp_is_pending
);

	// a waiting result holds until its transfer
	a_rsp_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_pick_id) &&
			$stable(rsp_status) && $stable(rsp_is_pending))
		else $error("result changed while stalled");

	// one item at a time: no transfer in the cycle after a transfer
	a_one_item: assert property (@(posedge clk) disable iff (!arst_n)
		req_valid && req_ready |=> !req_ready)
		else $error("input taken while an item is in work");

	// target and query answer only appear with an ok status
	a_fields_zero: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && (rsp_status != ST_OK) |-> (rsp_pick_id == '0) && !rsp_is_pending)
		else $error("result field set with error status");

	// a result never shows up right after an input transfer
	a_latency: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(rsp_valid) |-> !$past(req_valid && req_ready))
		else $error("result too early");

endmodule

bind priority_compaction_scheduler_unit pcs_checker u_pcs_checker (
	.clk            (clk),
	.arst_n         (arst_n),
	.req_valid      (req.valid),
	.req_ready      (req.ready),
	.rsp_valid      (rsp.valid),
	.rsp_ready      (rsp.ready),
	.rsp_status     (rsp.status),
	.rsp_pick_id    (rsp.pick_id),
	.rsp_is_pending (rsp.is_pending)
);
`default_nettype wire

[verif/testbench.sv]
// self-checking testbench for the priority compaction scheduler
`timescale 1ns / 1ps
module testbench;
	import pcs_pkg::*;

	localparam int CycleLimit = 600000;
	localparam int RandItems  = 1750;
	localparam int HoldCycles = 400;
	localparam int ReportMax  = 10;

	typedef enum int {
		MIX_FILL,
		MIX_DRAIN,
		MIX_BALANCED,
		MIX_NOISE
	} stim_mix_t;

	// predictor of the scheduler state and the queue of results still owed
	class sched_predictor;
		bit               pend_vld [PendDepthDef];
		bit [IdW-1:0]     pend_ids [PendDepthDef];
		bit signed [PrioW-1:0] pend_prio [PendDepthDef];
		bit               busy_vld [BusyDepthDef];
		bit [IdW-1:0]     busy_ids [BusyDepthDef];
		rsp_t             owed_q[$];
		int               mismatches;
		int               checked;
		int               status_count [4];

		function int find_pend(bit [IdW-1:0] id);
			for (int i = 0; i < PendDepthDef; i++)
				if (pend_vld[i] && pend_ids[i] == id)
					return i;
			return -1;
		endfunction

		function int find_busy(bit [IdW-1:0] id);
			for (int i = 0; i < BusyDepthDef; i++)
				if (busy_vld[i] && busy_ids[i] == id)
					return i;
			return -1;
		endfunction

		function int pend_count();
			int n;
			n = 0;
			foreach (pend_vld[i]) n += pend_vld[i];
			return n;
		endfunction

		function int busy_count();
			int n;
			n = 0;
			foreach (busy_vld[i]) n += busy_vld[i];
			return n;
		endfunction

		// random valid entry of the pending table, caller checks it is not empty
		function bit [IdW-1:0] pick_pend_id();
			int k;
			k = $urandom_range(pend_count() - 1);
			foreach (pend_vld[i])
				if (pend_vld[i]) begin
					if (k == 0) return pend_ids[i];
					k--;
				end
			return '0;
		endfunction

		function bit [IdW-1:0] pick_busy_id();
			int k;
			k = $urandom_range(busy_count() - 1);
			foreach (busy_vld[i])
				if (busy_vld[i]) begin
					if (k == 0) return busy_ids[i];
					k--;
				end
			return '0;
		endfunction

		function int outstanding();
			return owed_q.size();
		endfunction

		// apply one accepted input transfer and queue its result
		function void accept_item(action_t act, bit [IdW-1:0] id,
				bit signed [PrioW-1:0] prio);
			rsp_t r;
			int   slot;
			int   best;
			r.status     = ST_OK;
			r.pick_id    = '0;
			r.is_pending = 1'b0;
			case (act)
				ACT_REQUEST: begin
					slot = find_pend(id);
					if (slot >= 0) begin
						if (prio > pend_prio[slot])
							pend_prio[slot] = prio;
					end else begin
						slot = -1;
						for (int i = PendDepthDef - 1; i >= 0; i--)
							if (!pend_vld[i]) slot = i;
						if (slot >= 0) begin
							pend_vld[slot]  = 1'b1;
							pend_ids[slot]  = id;
							pend_prio[slot] = prio;
						end else
							r.status = ST_PEND_FULL;
					end
				end
				ACT_TAKE: begin
					best = -1;
					for (int i = 0; i < PendDepthDef; i++) begin
						if (!pend_vld[i] || pend_prio[i] < 0) continue;
						if (find_busy(pend_ids[i]) >= 0) continue;
						if (best < 0 || pend_prio[i] > pend_prio[best] ||
								(pend_prio[i] == pend_prio[best] &&
								pend_ids[i] < pend_ids[best]))
							best = i;
					end
					if (best < 0)
						r.status = ST_NONE;
					else begin
						slot = -1;
						for (int i = BusyDepthDef - 1; i >= 0; i--)
							if (!busy_vld[i]) slot = i;
						if (slot >= 0) begin
							busy_vld[slot]  = 1'b1;
							busy_ids[slot]  = pend_ids[best];
							pend_vld[best]  = 1'b0;
							r.pick_id       = pend_ids[best];
						end else
							r.status = ST_BUSY_FULL;
					end
				end
				ACT_COMPLETE: begin
					slot = find_busy(id);
					if (slot >= 0)
						busy_vld[slot] = 1'b0;
				end
				default: begin
					r.is_pending = (find_pend(id) >= 0);
				end
			endcase
			status_count[r.status]++;
			owed_q.insert(owed_q.size(), r);
		endfunction

		// compare one result transfer with the oldest owed result
		function void check_result(logic [1:0] st, logic [IdW-1:0] tid, logic pend);
			rsp_t e;
			if (owed_q.size() == 0) begin
				mismatches++;
				if (mismatches <= ReportMax)
					$display("result with nothing owed: status %0d target %h pending %b",
						st, tid, pend);
				return;
			end
			e = owed_q.pop_front();
			checked++;
			if (st !== e.status || tid !== e.pick_id || pend !== e.is_pending) begin
				mismatches++;
				if (mismatches <= ReportMax)
					$display({"mismatch at result %0d: exp status %0d target %h pending %b,",
						" got status %0d target %h pending %b"},
						checked, e.status, e.pick_id, e.is_pending, st, tid, pend);
			end
		endfunction
	endclass

	logic clk;
	logic arst_n;
	int   cycles;
	bit   calm;
	int   hold_asked;
	int   items_sent;

	sched_predictor model;

	pcs_req_if req_if ();
	pcs_rsp_if rsp_if ();

	priority_compaction_scheduler_unit dut (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req_if),
		.rsp    (rsp_if)
	);

	// clock
	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	// run watchdog
	initial cycles = 0;
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles >= CycleLimit) begin
			$display("testbench: FAIL");
			$finish;
		end
	end

	// offer one item, idling first at random, and note it once the transfer happens
	task automatic send_item(input action_t act, input bit [IdW-1:0] id,
			input bit signed [PrioW-1:0] prio);
		while (!calm && $urandom_range(99) < 27) begin
			req_if.valid <= 1'b0;
			@(posedge clk);
		end
		req_if.valid        <= 1'b1;
		req_if.action       <= act;
		req_if.part_id      <= id;
		req_if.priority_req <= prio;
		do @(posedge clk); while (!req_if.ready);
		model.accept_item(act, id, prio);
		items_sent++;
	endtask

	// id draw biased toward a small pool so that entries collide and tables fill
	function automatic bit [IdW-1:0] draw_id(stim_mix_t mix);
		int r;
		r = $urandom_range(99);
		if (mix == MIX_NOISE) return IdW'($urandom_range(16'hffff));
		if (r < 55)
			return (mix == MIX_FILL) ? IdW'($urandom_range(47)) : IdW'($urandom_range(23));
		if (r < 70 && model.pend_count() > 0) return model.pick_pend_id();
		if (r < 78)
			case ($urandom_range(3))
				0: return 16'h0000;
				1: return 16'hffff;
				2: return 16'h8000;
				default: return 16'h7fff;
			endcase
		return IdW'($urandom_range(16'hffff));
	endfunction

	function automatic bit signed [PrioW-1:0] draw_prio();
		int r;
		r = $urandom_range(99);
		if (r < 40) return PrioW'($urandom_range(16'hffff));
		if (r < 75) return PrioW'(int'($urandom_range(16)) - 4);
		if (r < 85)
			case ($urandom_range(3))
				0: return -16'sd32768;
				1: return 16'sd32767;
				2: return 16'sd0;
				default: return -16'sd1;
			endcase
		return PrioW'($urandom_range(16'h7fff));
	endfunction

	// one random item shaped by the current mix
	task automatic send_random(input stim_mix_t mix);
		int      r;
		int      w_req;
		int      w_take;
		int      w_cmp;
		action_t act;
		bit [IdW-1:0] id;
		case (mix)
			MIX_FILL:  begin w_req = 70; w_take = 10; w_cmp = 10; end
			MIX_DRAIN: begin w_req = 20; w_take = 55; w_cmp = 10; end
			MIX_BALANCED: begin w_req = 35; w_take = 25; w_cmp = 25; end
			default:   begin w_req = 25; w_take = 25; w_cmp = 25; end
		endcase
		r = $urandom_range(99);
		if (r < w_req) act = ACT_REQUEST;
		else if (r < w_req + w_take) act = ACT_TAKE;
		else if (r < w_req + w_take + w_cmp) act = ACT_COMPLETE;
		else act = ACT_QUERY;
		id = draw_id(mix);
		if (act == ACT_COMPLETE && mix != MIX_NOISE && model.busy_count() > 0 &&
				$urandom_range(99) < 75)
			id = model.pick_busy_id();
		send_item(act, id, draw_prio());
	endtask

	// result side: check each transfer, stall at random or for a long hold-off
	initial begin : rsp_sink
		int hold_left;
		int hold_done;
		hold_left = 0;
		hold_done = 0;
		rsp_if.ready <= 1'b0;
		forever begin
			@(posedge clk);
			if (arst_n && rsp_if.valid && rsp_if.ready)
				model.check_result(rsp_if.status, rsp_if.pick_id, rsp_if.is_pending);
			if (hold_left > 0) begin
				hold_left--;
				rsp_if.ready <= 1'b0;
			end else if (hold_done != hold_asked) begin
				hold_done++;
				hold_left = HoldCycles;
				rsp_if.ready <= 1'b0;
			end else
				rsp_if.ready <= calm || ($urandom_range(99) >= 27);
		end
	end

	// main sequence
	initial begin
		stim_mix_t mix;
		model      = new();
		calm       = 1'b0;
		hold_asked = 0;
		items_sent = 0;
		arst_n = 1'b0;
		req_if.valid        <= 1'b0;
		req_if.action       <= ACT_REQUEST;
		req_if.part_id      <= '0;
		req_if.priority_req <= '0;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: empty tables, extremes, raise rules, ties, busy ids, zero priority
		send_item(ACT_QUERY,    16'h0000, 16'sd0);
		send_item(ACT_TAKE,     16'h0000, 16'sd0);
		send_item(ACT_COMPLETE, 16'hffff, 16'sd0);
		send_item(ACT_REQUEST,  16'h0000, -16'sd32768);
		send_item(ACT_TAKE,     16'hffff, 16'sd0);
		send_item(ACT_REQUEST,  16'hffff, 16'sd32767);
		send_item(ACT_REQUEST,  16'hffff, 16'sd100);
		send_item(ACT_REQUEST,  16'h0000, 16'sd32767);
		send_item(ACT_TAKE,     16'h0000, 16'sd0);
		send_item(ACT_QUERY,    16'h0000, 16'sd0);
		send_item(ACT_QUERY,    16'hffff, -16'sd1);
		send_item(ACT_REQUEST,  16'h0000, 16'sd0);
		send_item(ACT_TAKE,     16'h0000, 16'sd0);
		send_item(ACT_TAKE,     16'h0000, 16'sd0);
		send_item(ACT_COMPLETE, 16'h0000, 16'sd0);
		send_item(ACT_TAKE,     16'h0000, 16'sd0);
		send_item(ACT_REQUEST,  16'h5555, -16'sd1);
		send_item(ACT_REQUEST,  16'haaaa, 16'sh2aaa);
		send_item(ACT_QUERY,    16'h5555, 16'sd0);
		send_item(ACT_TAKE,     16'h0000, 16'sd0);
		send_item(ACT_COMPLETE, 16'hffff, 16'sd0);
		send_item(ACT_COMPLETE, 16'h0000, 16'sd0);
		send_item(ACT_COMPLETE, 16'haaaa, 16'sd0);

		// random phases, with a quiet stretch and two long result hold-offs
		mix = MIX_FILL;
		for (int n = 0; n < RandItems; n++) begin
			if (n % 60 == 0)
				mix = stim_mix_t'($urandom_range(3));
			calm = (n >= 700 && n < 1000);
			if (n == 300 || n == 1200)
				hold_asked++;
			send_random(mix);
		end
		req_if.valid <= 1'b0;

		while (model.outstanding() != 0) @(posedge clk);
		repeat (40) @(posedge clk);

		$display("run covered %0d items and %0d results: ok %0d, none eligible %0d",
			items_sent, model.checked, model.status_count[ST_OK],
			model.status_count[ST_NONE]);
		$display("pending full %0d, busy full %0d, mismatches %0d",
			model.status_count[ST_PEND_FULL], model.status_count[ST_BUSY_FULL],
			model.mismatches);
		if (model.mismatches == 0 && model.outstanding() == 0)
			$display("testbench: PASS");
		else
			$display("testbench: FAIL");
		$finish;
	end

endmodule
